>>> rtl/lfd_pkg.sv
// Shared constants and helpers for the LED fade controller with auto-dim timeout.
package lfd_pkg;

    localparam int unsigned LEVEL_W    = 8;
    localparam int unsigned REQ_W      = 11;
    localparam int unsigned SECS_W     = 16;
    localparam int unsigned MS_W       = 26;
    localparam int unsigned STEP_EL_W  = 9;

    localparam logic [LEVEL_W-1:0]   LEVEL_OFF     = '0;
    localparam logic [LEVEL_W-1:0]   LEVEL_MAX     = '1;
    localparam logic [MS_W-1:0]      MS_PER_SECOND = MS_W'(1000);
    // Timeout armed by the first expiry: 10 s in milliseconds
    localparam logic [MS_W-1:0]      DIM_LIMIT_MS  = MS_W'(10000);
    localparam logic [MS_W-1:0]      MS_SAT        = '1;
    localparam logic [STEP_EL_W-1:0] STEP_EL_SAT   = '1;

    // Reciprocal of three for 8-bit values: floor(x * 171 / 512) == floor(x / 3)
    localparam logic [LEVEL_W:0]     DIV3_RECIP    = 9'd171;
    localparam int unsigned          DIV3_SHIFT    = 9;

    typedef logic [LEVEL_W-1:0] t_level;

    // Divide a brightness level by three without a divider
    function automatic t_level div3(input t_level x);
        logic [2*LEVEL_W:0] prod;
        prod = {{(LEVEL_W+1){1'b0}}, x} * {{LEVEL_W{1'b0}}, DIV3_RECIP};
        return t_level'(prod >> DIV3_SHIFT);
    endfunction

    // Clamp a signed request to 0..255
    function automatic t_level clamp_level(input logic signed [REQ_W-1:0] req);
        t_level lvl;
        if (req[REQ_W-1]) begin
            lvl = LEVEL_OFF;
        end else if (req[REQ_W-2:LEVEL_W] != '0) begin
            lvl = LEVEL_MAX;
        end else begin
            lvl = req[LEVEL_W-1:0];
        end
        return lvl;
    endfunction

endpackage

>>> rtl/led_fade_with_auto_dim_timeout.sv
// LED fade controller: ramp toward a goal level with an automatic dim and off timeout.
//
//  channel   direction  handshake            payload
//  --------  ---------  -------------------  -------------------------------------------
//  item in   input      i_valid / o_stall    i_action, i_requested_level, i_timeout_seconds
//  result    output     o_valid / i_stall    o_drive_level, o_level_updated,
//                                            o_goal_level, o_timer_active
//  config    input      i_cfg_we             i_cfg_wdata (step_period_ms)
//
// Each accepted transaction updates the state registers and the result
// register together, so one transaction per cycle is sustained unless o_stall holds input off.
// The result appears in the output register in the cycle after acceptance.
// Synchronous active-low reset clears the controller state and the result valid flag; step period resets to 10 ms.
// o_stall is high only while a held result is stalled downstream.
module led_fade_with_auto_dim_timeout
    import lfd_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic                      i_action,
    input  logic signed [REQ_W-1:0]   i_requested_level,
    input  logic [SECS_W-1:0]         i_timeout_seconds,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [LEVEL_W-1:0]        o_drive_level,
    output logic                      o_level_updated,
    output logic [LEVEL_W-1:0]        o_goal_level,
    output logic                      o_timer_active,
    input  logic                      i_cfg_we,
    input  logic [LEVEL_W-1:0]        i_cfg_wdata
);

    // State
    logic [LEVEL_W-1:0]   r_period;
    logic [LEVEL_W-1:0]   r_goal,     n_goal;
    logic [LEVEL_W-1:0]   r_drive,    n_drive;
    logic [MS_W-1:0]      r_limit,    n_limit;
    logic [MS_W-1:0]      r_elapsed,  n_elapsed;
    logic [STEP_EL_W-1:0] r_step_el,  n_step_el;
    logic                 r_due,      n_due;
    logic                 r_dimmed,   n_dimmed;
    logic                 r_out_valid;
    logic                 r_updated,  n_updated;
    logic [LEVEL_W-1:0]   r_res_drive;
    logic [LEVEL_W-1:0]   r_res_goal;
    logic                 r_res_timer;

    logic                 accept;
    logic                 expire;
    logic [LEVEL_W-1:0]   req_level;
    logic [LEVEL_W-1:0]   dim_level;
    logic [MS_W-1:0]      el_inc;
    logic [STEP_EL_W-1:0] step_inc;

    // Handshake: hold off input only while a result waits on a stalled sink
    assign o_stall = r_out_valid & i_stall;
    assign accept  = i_valid & ~o_stall;

    assign req_level = clamp_level(i_requested_level);
    assign dim_level = div3(r_goal);
    assign el_inc    = (r_elapsed == MS_SAT) ? r_elapsed : r_elapsed + 1'b1;
    assign step_inc  = (r_step_el == STEP_EL_SAT) ? r_step_el : r_step_el + 1'b1;
    assign expire    = ~i_action & (r_limit != '0) & (el_inc > r_limit);

    // Next-state logic for one transaction
    always_comb begin
        n_goal    = r_goal;
        n_drive   = r_drive;
        n_limit   = r_limit;
        n_elapsed = r_elapsed;
        n_step_el = r_step_el;
        n_due     = r_due;
        n_dimmed  = r_dimmed;
        n_updated = 1'b0;

        if (i_action) begin
            // fade command: new goal, re-arm timer
            n_goal    = req_level;
            n_due     = r_due | (req_level != r_goal);
            n_limit   = MS_W'(i_timeout_seconds) * MS_PER_SECOND;
            n_elapsed = '0;
            n_dimmed  = 1'b0;
        end else begin
            // tick: advance counters, then timeout, then ramp
            n_elapsed = el_inc;
            n_step_el = step_inc;
            if (expire) begin
                n_elapsed = '0;
                if (!r_dimmed) begin
                    n_goal   = dim_level;
                    n_due    = r_due | (dim_level != r_goal);
                    n_limit  = DIM_LIMIT_MS;
                    n_dimmed = 1'b1;
                end else begin
                    n_goal   = LEVEL_OFF;
                    n_due    = r_due | (r_goal != LEVEL_OFF);
                    n_limit  = '0;
                    n_dimmed = 1'b0;
                end
            end
            if ((r_drive != n_goal) && (n_due || ({1'b0, r_period} < step_inc))) begin
                n_drive   = (r_drive < n_goal) ? r_drive + 1'b1 : r_drive - 1'b1;
                n_step_el = '0;
                n_due     = 1'b0;
                n_updated = 1'b1;
            end
        end
    end

    // State and configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period  <= LEVEL_W'(10);
            r_goal    <= '0;
            r_drive   <= '0;
            r_limit   <= '0;
            r_elapsed <= '0;
            r_step_el <= '0;
            r_due     <= 1'b0;
            r_dimmed  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_period <= i_cfg_wdata;
            end
            if (accept) begin
                r_goal    <= n_goal;
                r_drive   <= n_drive;
                r_limit   <= n_limit;
                r_elapsed <= n_elapsed;
                r_step_el <= n_step_el;
                r_due     <= n_due;
                r_dimmed  <= n_dimmed;
            end
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res_drive <= n_drive;
            r_updated   <= n_updated;
            r_res_goal  <= n_goal;
            r_res_timer <= (n_limit != '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_drive_level   = r_res_drive;
    assign o_level_updated = r_updated;
    assign o_goal_level    = r_res_goal;
    assign o_timer_active  = r_res_timer;

`ifndef NO_ASSERTIONS
    // Accepted transaction always yields a visible result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("result missing after accepted transaction");

    // Result register mirrors the updated controller state
    a_result_matches_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_drive_level == r_drive) && (o_goal_level == r_goal)
                   && (o_timer_active == (r_limit != '0)))
        else $error("result disagrees with controller state");

    // Drive level moves only on an accepted tick
    a_drive_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_drive) |-> $past(accept && !i_action))
        else $error("drive level changed without a tick");

    // A reported step restarts the step counter and clears the due flag
    a_step_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && n_updated) |=> (r_step_el == '0) && !r_due)
        else $error("step did not restart step timing");
`endif

endmodule
